FILE: rtl/core/bfs_shortest_path_engine_assert.svh
// Assertion macros for the shortest path engine
`ifndef BFS_SHORTEST_PATH_ENGINE_ASSERT_SVH
`define BFS_SHORTEST_PATH_ENGINE_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define BSP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bsp check failed");
// Next-cycle implication outside reset
`define BSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bsp check failed");
`endif

FILE: rtl/core/bsp_pkg.sv
// ---------------------------------------------------------------------------
// bsp_pkg
// Shared types and codes for the shortest path engine.
// ---------------------------------------------------------------------------
package bsp_pkg;
  localparam logic [1:0] REQ_ADD_NODE = 2'd0;
  localparam logic [1:0] REQ_ADD_EDGE = 2'd1;
  localparam logic [1:0] REQ_FIND     = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_NO_PATH = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] node_a;
    logic [3:0] node_b;
  } req_t;

  typedef struct packed {
    logic [3:0] path_node;
    logic [3:0] hop_count;
    logic [1:0] status;
    logic       last;
  } rsp_t;
endpackage

FILE: rtl/core/bsp_if.sv
// ---------------------------------------------------------------------------
// bsp_req_if / bsp_rsp_if
// Valid/ready channels for requests and results.
// ---------------------------------------------------------------------------
interface bsp_req_if;
  logic          valid;
  logic          ready;
  bsp_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bsp_rsp_if;
  logic          valid;
  logic          ready;
  bsp_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/bfs_shortest_path_engine.sv
// Sequence: add node answers from idle; add edge also passes S_EDGE2. A query
// reads each dequeued node (S_DEQ, S_QRD) and each neighbor entry (S_NRD, S_NCHK),
// then walks the parents (S_WALK, S_PRD) and sends each path result in turn.
// Throughput: one item at a time; the next request transfers the cycle after the
// last result of the previous item transfers.
// Reset: presence bits, neighbor counts, visited marks and queue pointers clear at
// once; neighbor, parent, queue and path memories are only read after writing.
// ---------------------------------------------------------------------------
// bfs_shortest_path_engine
// Breadth-first shortest path search over an undirected graph in memory.
// ---------------------------------------------------------------------------
module bfs_shortest_path_engine #(
  parameter int MAX_NODES  = 16,
  parameter int MAX_DEGREE = 8
) (
  input logic      clk,
  input logic      rst,
  bsp_req_if.sink   req,
  bsp_rsp_if.source rsp
);
  localparam int NW = 4;
  localparam int DW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int CW = $clog2(MAX_DEGREE + 1);
  localparam int AW = NW + DW;
  localparam int QW = 5;
  localparam int NN = (MAX_NODES < 16) ? MAX_NODES : 16;
  localparam logic [QW-1:0] QMAX = QW'(NN);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EDGE2 = 4'd1;
  localparam logic [3:0] S_DEQ   = 4'd2;
  localparam logic [3:0] S_QRD   = 4'd3;
  localparam logic [3:0] S_NRD   = 4'd4;
  localparam logic [3:0] S_NCHK  = 4'd5;
  localparam logic [3:0] S_WALK  = 4'd6;
  localparam logic [3:0] S_PRD   = 4'd7;
  localparam logic [3:0] S_OUTR  = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;
  localparam logic [3:0] S_RSP   = 4'd10;

  // node_present, neighbor_count and visited live in flops (16 entries)
  logic [15:0]   present;
  logic [CW-1:0] ncount [16];
  logic [15:0]   visited;

  // memories
  logic [NW-1:0] nbr_mem [16 << DW];
  logic [NW-1:0] par_mem [16];
  logic [NW-1:0] que_mem [16];
  logic [NW-1:0] stk_mem [16];
  logic [NW-1:0] nbr_q, par_q, que_q, stk_q;

  logic [3:0]    state;
  bsp_pkg::req_t cur_req;
  logic [QW-1:0] head, tail, len;
  logic [3:0]    cur, step;
  logic [CW-1:0] idx;
  logic [3:0]    hop;
  logic [QW-1:0] oidx;
  bsp_pkg::rsp_t out_d;
  logic          out_v;

  logic          a_ok, b_ok, full;
  logic [CW:0]   ca2, cb1, ca1;
  logic [AW-1:0] nbr_raddr;
  logic          nbr_ren;

  assign req.ready = (state == S_IDLE) && !out_v;
  assign rsp.valid = out_v;
  assign rsp.data  = out_d;

  // range checks for a request and room checks for an edge add
  assign a_ok = 32'(req.data.node_a) < MAX_NODES;
  assign b_ok = 32'(req.data.node_b) < MAX_NODES;
  assign ca1  = (CW+1)'(ncount[req.data.node_a]) + (CW+1)'(1);
  assign ca2  = (CW+1)'(ncount[req.data.node_a]) + (CW+1)'(2);
  assign cb1  = (CW+1)'(ncount[req.data.node_b]) + (CW+1)'(1);
  assign full = (req.data.node_a == req.data.node_b) ? (32'(ca2) > MAX_DEGREE)
              : ((32'(ca1) > MAX_DEGREE) || (32'(cb1) > MAX_DEGREE));

  assign nbr_raddr = AW'({cur, idx[DW-1:0]});
  assign nbr_ren   = (state == S_NRD);

  // Build a single-result answer with the given status
  function automatic bsp_pkg::rsp_t done_rsp(input logic [1:0] st);
    bsp_pkg::rsp_t r;
    r.path_node = '0;
    r.hop_count = '0;
    r.status    = st;
    r.last      = 1'b1;
    return r;
  endfunction

  // memory read ports: neighbor (enabled), queue, parent and path stack
  always_ff @(posedge clk) begin
    if (nbr_ren) nbr_q <= nbr_mem[nbr_raddr];
    que_q <= que_mem[head[3:0]];
    par_q <= par_mem[step];
    stk_q <= stk_mem[len[3:0] - oidx[3:0] - 4'd1];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      present <= '0;
      visited <= '0;
      out_v   <= 1'b0;
      head    <= '0;
      tail    <= '0;
      for (int i = 0; i < 16; i++) ncount[i] <= '0;
    end else begin
      if (out_v && rsp.ready) out_v <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            cur_req <= req.data;
            case (req.data.req_type)
              bsp_pkg::REQ_ADD_NODE: begin
                if (!a_ok) out_d <= done_rsp(bsp_pkg::ST_UNKNOWN);
                else begin
                  out_d <= done_rsp(bsp_pkg::ST_OK);
                  present[req.data.node_a] <= 1'b1;
                end
                out_v <= 1'b1;
              end
              bsp_pkg::REQ_ADD_EDGE: begin
                if (!a_ok || !b_ok) begin
                  out_d <= done_rsp(bsp_pkg::ST_UNKNOWN);
                  out_v <= 1'b1;
                end else if (full) begin
                  out_d <= done_rsp(bsp_pkg::ST_FULL);
                  out_v <= 1'b1;
                end else begin
                  out_d <= done_rsp(bsp_pkg::ST_OK);
                  nbr_mem[AW'({req.data.node_a, ncount[req.data.node_a][DW-1:0]})]
                    <= req.data.node_b;
                  ncount[req.data.node_a] <= ncount[req.data.node_a] + CW'(1);
                  present <= present | (16'd1 << req.data.node_a)
                             | (16'd1 << req.data.node_b);
                  state <= S_EDGE2;
                end
              end
              bsp_pkg::REQ_FIND: begin
                if (!a_ok || !b_ok || !present[req.data.node_a]
                    || !present[req.data.node_b]) begin
                  out_d <= done_rsp(bsp_pkg::ST_UNKNOWN);
                  out_v <= 1'b1;
                end else begin
                  out_d <= done_rsp(bsp_pkg::ST_OK);
                  visited <= 16'd1 << req.data.node_a;
                  par_mem[req.data.node_a] <= req.data.node_a;
                  que_mem[0] <= req.data.node_a;
                  head  <= '0;
                  tail  <= QW'(1);
                  state <= S_DEQ;
                end
              end
              default: ;
            endcase
          end
        end
        S_EDGE2: begin
          // second list append, after the first count update
          nbr_mem[AW'({cur_req.node_b, ncount[cur_req.node_b][DW-1:0]})] <= cur_req.node_a;
          ncount[cur_req.node_b] <= ncount[cur_req.node_b] + CW'(1);
          out_v <= 1'b1;
          state <= S_IDLE;
        end
        S_DEQ: begin
          if (head == tail) begin
            out_d.status <= bsp_pkg::ST_NO_PATH;
            out_v <= 1'b1;
            state <= S_IDLE;
          end else state <= S_QRD;
        end
        S_QRD: begin
          cur  <= que_q;
          head <= head + QW'(1);
          idx  <= '0;
          if (que_q == cur_req.node_b) begin
            step <= cur_req.node_b;
            len  <= '0;
            state <= S_WALK;
          end else state <= S_NRD;
        end
        S_NRD: begin
          if (idx >= ncount[cur] || 32'(idx) >= MAX_DEGREE) state <= S_DEQ;
          else state <= S_NCHK;
        end
        S_NCHK: begin
          if (32'(nbr_q) < MAX_NODES && !visited[nbr_q] && tail < QMAX) begin
            visited[nbr_q] <= 1'b1;
            par_mem[nbr_q] <= cur;
            que_mem[tail[3:0]] <= nbr_q;
            tail <= tail + QW'(1);
          end
          idx   <= idx + CW'(1);
          state <= S_NRD;
        end
        S_WALK: begin
          stk_mem[len[3:0]] <= step;
          len <= len + QW'(1);
          if (step == cur_req.node_a || len + QW'(1) >= QMAX) begin
            hop  <= len[3:0];
            oidx <= '0;
            state <= S_OUTR;
          end else state <= S_PRD;
        end
        S_PRD: begin
          step  <= par_q;
          state <= S_WALK;
        end
        S_OUTR: state <= S_OUT;
        S_OUT: begin
          if (!out_v) begin
            out_d <= '{path_node: stk_q, hop_count: hop, status: bsp_pkg::ST_OK,
                       last: (oidx + QW'(1) == len)};
            out_v <= 1'b1;
            oidx  <= oidx + QW'(1);
            state <= S_RSP;
          end
        end
        S_RSP: begin
          if (oidx == len) state <= S_IDLE;
          else state <= S_OUTR;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `include "bfs_shortest_path_engine_assert.svh"
  `BSP_ASSERT_IMPL(a_ready_idle, req.ready, state == S_IDLE)
  `BSP_ASSERT_IMPL(a_tail_bound, state != S_IDLE, tail <= QMAX)
  `BSP_ASSERT_IMPL(a_head_tail, state == S_QRD, head < tail)
  `BSP_ASSERT_NEXT(a_hold, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.data))
endmodule

FILE: tb/testbench.sv
// ---------------------------------------------------------------------------
// Shortest path engine testbench
// Builds graphs through the request channel and runs path queries against
// them. A behavioral graph model in the bench predicts the results that the
// directed rows do not give themselves. Both channels idle at random, and
// the results are checked in order, field by field.
// ---------------------------------------------------------------------------
module testbench;
  localparam int NODES      = 16;
  localparam int DEGREE     = 8;
  localparam int RAND_ITEMS = 240;
  localparam int CYCLE_CAP  = 900000;
  localparam int LONG_HOLD  = 400;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    bsp_pkg::req_t r;
    bit            typed;
    bsp_pkg::rsp_t want;
  } stim_row_t;

  logic clk;
  logic rst;
  int   cycles = 0;
  int   errors = 0;
  int   mismatches = 0;
  bit   quiet;
  bit   hold_go;
  bit   long_hold;
  int   hold_left;
  int   stall;

  bsp_req_if req_if ();
  bsp_rsp_if rsp_if ();

  bfs_shortest_path_engine u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if.sink),
    .rsp (rsp_if.source)
  );

  // Graph model state
  bit            node_up [NODES];
  int            deg     [NODES];
  logic [3:0]    adj     [NODES][DEGREE];
  bsp_pkg::rsp_t pending_results [$];
  stim_row_t     rows [$];

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic bsp_pkg::rsp_t mk_rsp(logic [3:0] n, logic [3:0] h, logic [1:0] st,
                                           logic l);
    bsp_pkg::rsp_t x;
    x.path_node = n;
    x.hop_count = h;
    x.status    = st;
    x.last      = l;
    return x;
  endfunction

  // Append one expected result
  function automatic void expect_result(bsp_pkg::rsp_t x);
    pending_results.insert(pending_results.size(), x);
  endfunction

  // Append one directed stimulus row
  function automatic void add_row(logic [1:0] t, logic [3:0] a, logic [3:0] b, bit typed,
                                  bsp_pkg::rsp_t want);
    stim_row_t row;
    row.r.req_type = t;
    row.r.node_a   = a;
    row.r.node_b   = b;
    row.typed      = typed;
    row.want       = want;
    rows.insert(rows.size(), row);
  endfunction

  // Apply one request to the graph model and queue the results it causes
  function automatic void graph_step(bsp_pkg::req_t r);
    logic [3:0] a;
    logic [3:0] b;
    logic [3:0] cur;
    logic [3:0] step;
    logic [3:0] q [NODES];
    logic [3:0] par [NODES];
    logic [3:0] path [$];
    bit         seen [NODES];
    int         head;
    int         tail;
    bit         found;
    a = r.node_a;
    b = r.node_b;
    case (r.req_type)
      bsp_pkg::REQ_ADD_NODE: begin
        node_up[a] = 1'b1;
        expect_result(mk_rsp(4'd0, 4'd0, bsp_pkg::ST_OK, 1'b1));
      end
      bsp_pkg::REQ_ADD_EDGE: begin
        if ((a == b) ? (deg[a] + 2 > DEGREE)
                     : (deg[a] + 1 > DEGREE || deg[b] + 1 > DEGREE)) begin
          expect_result(mk_rsp(4'd0, 4'd0, bsp_pkg::ST_FULL, 1'b1));
        end else begin
          adj[a][deg[a]] = b;
          deg[a]++;
          adj[b][deg[b]] = a;
          deg[b]++;
          node_up[a] = 1'b1;
          node_up[b] = 1'b1;
          expect_result(mk_rsp(4'd0, 4'd0, bsp_pkg::ST_OK, 1'b1));
        end
      end
      bsp_pkg::REQ_FIND: begin
        if (!node_up[a] || !node_up[b]) begin
          expect_result(mk_rsp(4'd0, 4'd0, bsp_pkg::ST_UNKNOWN, 1'b1));
        end else begin
          foreach (seen[i]) seen[i] = 1'b0;
          seen[a] = 1'b1;
          par[a] = a;
          q[0] = a;
          head = 0;
          tail = 1;
          found = 1'b0;
          // Expand the frontier in list order until the target dequeues
          while (head < tail && !found) begin
            cur = q[head];
            head++;
            if (cur == b) begin
              found = 1'b1;
            end else begin
              for (int i = 0; i < deg[cur]; i++) begin
                if (!seen[adj[cur][i]] && tail < NODES) begin
                  seen[adj[cur][i]] = 1'b1;
                  par[adj[cur][i]] = cur;
                  q[tail] = adj[cur][i];
                  tail++;
                end
              end
            end
          end
          if (!found) begin
            expect_result(mk_rsp(4'd0, 4'd0, bsp_pkg::ST_NO_PATH, 1'b1));
          end else begin
            // Walk parents back from the target
            step = b;
            while (path.size() < NODES) begin
              path.push_front(step);
              if (step == a) break;
              step = par[step];
            end
            foreach (path[i]) begin
              expect_result(mk_rsp(path[i], 4'(path.size() - 1), bsp_pkg::ST_OK,
                                   i == path.size() - 1));
            end
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Offer one request and hold it until the transfer
  task automatic send_req(bsp_pkg::req_t r, bit typed, bsp_pkg::rsp_t want);
    int before_n;
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    before_n = pending_results.size();
    graph_step(r);
    if (typed) begin
      while (pending_results.size() > before_n) void'(pending_results.pop_back());
      expect_result(want);
    end
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // Hold the result side off for a long stretch once asked
  initial begin
    long_hold = 1'b0;
    hold_left = 0;
    wait (hold_go);
    @(posedge clk);
    long_hold = 1'b1;
    hold_left = LONG_HOLD;
    while (hold_left > 0) begin
      @(posedge clk);
      hold_left--;
    end
    long_hold = 1'b0;
  end

  // Result side: check each transfer, then pick ready for the next cycle
  initial begin
    bsp_pkg::rsp_t exp_r;
    rsp_if.ready <= 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_if.valid && rsp_if.ready) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("unexpected result %p", rsp_if.data);
        end else begin
          exp_r = pending_results.pop_front();
          if (rsp_if.data !== exp_r) begin
            errors++;
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected node %0d hops %0d status %0d last %0d",
                       exp_r.path_node, exp_r.hop_count, exp_r.status, exp_r.last);
              $display("          got node %0d hops %0d status %0d last %0d",
                       rsp_if.data.path_node, rsp_if.data.hop_count,
                       rsp_if.data.status, rsp_if.data.last);
            end
          end
        end
      end
      if (long_hold) begin
        rsp_if.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        rsp_if.ready <= 1'b0;
      end else if (!quiet && !rst && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 19) - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Stimulus
  initial begin
    bsp_pkg::req_t r;
    int            pick;
    bsp_pkg::rsp_t none;
    quiet = 1'b0;
    hold_go = 1'b0;
    none = mk_rsp(4'd0, 4'd0, bsp_pkg::ST_OK, 1'b0);
    foreach (node_up[i]) begin
      node_up[i] = 1'b0;
      deg[i] = 0;
    end
    rst <= 1'b1;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed rows: empty graph, extremes, self loops, overflow, unused code
    add_row(bsp_pkg::REQ_FIND, 4'd0, 4'd15, 1,
            mk_rsp(4'd0, 4'd0, bsp_pkg::ST_UNKNOWN, 1'b1));
    add_row(bsp_pkg::REQ_ADD_NODE, 4'd0, 4'd15, 1,
            mk_rsp(4'd0, 4'd0, bsp_pkg::ST_OK, 1'b1));
    add_row(bsp_pkg::REQ_FIND, 4'd0, 4'd0, 1, mk_rsp(4'd0, 4'd0, bsp_pkg::ST_OK, 1'b1));
    add_row(bsp_pkg::REQ_ADD_NODE, 4'd15, 4'd0, 1,
            mk_rsp(4'd0, 4'd0, bsp_pkg::ST_OK, 1'b1));
    add_row(bsp_pkg::REQ_FIND, 4'd0, 4'd15, 1,
            mk_rsp(4'd0, 4'd0, bsp_pkg::ST_NO_PATH, 1'b1));
    add_row(bsp_pkg::REQ_FIND, 4'd15, 4'd15, 1,
            mk_rsp(4'd15, 4'd0, bsp_pkg::ST_OK, 1'b1));
    add_row(bsp_pkg::REQ_ADD_EDGE, 4'd0, 4'd7, 1, mk_rsp(4'd0, 4'd0, bsp_pkg::ST_OK, 1'b1));
    add_row(bsp_pkg::REQ_ADD_EDGE, 4'd7, 4'd8, 1, mk_rsp(4'd0, 4'd0, bsp_pkg::ST_OK, 1'b1));
    add_row(bsp_pkg::REQ_ADD_EDGE, 4'd8, 4'd15, 1,
            mk_rsp(4'd0, 4'd0, bsp_pkg::ST_OK, 1'b1));
    add_row(bsp_pkg::REQ_ADD_EDGE, 4'd0, 4'd7, 1, mk_rsp(4'd0, 4'd0, bsp_pkg::ST_OK, 1'b1));
    add_row(bsp_pkg::REQ_FIND, 4'd0, 4'd15, 0, none);
    add_row(bsp_pkg::REQ_FIND, 4'd15, 4'd0, 0, none);
    add_row(bsp_pkg::REQ_ADD_EDGE, 4'd5, 4'd5, 1, mk_rsp(4'd0, 4'd0, bsp_pkg::ST_OK, 1'b1));
    add_row(bsp_pkg::REQ_ADD_EDGE, 4'd5, 4'd5, 1, mk_rsp(4'd0, 4'd0, bsp_pkg::ST_OK, 1'b1));
    add_row(bsp_pkg::REQ_ADD_EDGE, 4'd5, 4'd5, 1, mk_rsp(4'd0, 4'd0, bsp_pkg::ST_OK, 1'b1));
    add_row(bsp_pkg::REQ_ADD_EDGE, 4'd5, 4'd6, 1, mk_rsp(4'd0, 4'd0, bsp_pkg::ST_OK, 1'b1));
    add_row(bsp_pkg::REQ_ADD_EDGE, 4'd5, 4'd5, 1,
            mk_rsp(4'd0, 4'd0, bsp_pkg::ST_FULL, 1'b1));
    add_row(bsp_pkg::REQ_ADD_EDGE, 4'd6, 4'd5, 1, mk_rsp(4'd0, 4'd0, bsp_pkg::ST_OK, 1'b1));
    add_row(bsp_pkg::REQ_ADD_EDGE, 4'd5, 4'd6, 1,
            mk_rsp(4'd0, 4'd0, bsp_pkg::ST_FULL, 1'b1));
    add_row(bsp_pkg::REQ_FIND, 4'd6, 4'd5, 0, none);
    add_row(bsp_pkg::REQ_FIND, 4'd5, 4'd0, 1,
            mk_rsp(4'd0, 4'd0, bsp_pkg::ST_NO_PATH, 1'b1));
    add_row(bsp_pkg::REQ_FIND, 4'd9, 4'd0, 1,
            mk_rsp(4'd0, 4'd0, bsp_pkg::ST_UNKNOWN, 1'b1));
    add_row(REQ_UNUSED, 4'd15, 4'd15, 0, none);
    add_row(bsp_pkg::REQ_ADD_NODE, 4'd10, 4'd0, 1,
            mk_rsp(4'd0, 4'd0, bsp_pkg::ST_OK, 1'b1));
    foreach (rows[i]) send_req(rows[i].r, rows[i].typed, rows[i].want);

    // Random part: build the graph early, then mostly queries
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == 90) hold_go = 1'b1;
      if (i == 150) begin
        req_if.valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(posedge clk);
      end
      if (i == RAND_ITEMS - 40) quiet = 1'b1;
      pick = $urandom_range(0, 99);
      r.node_a = 4'($urandom_range(0, 15));
      r.node_b = 4'($urandom_range(0, 15));
      if (i < 40) begin
        r.req_type = (pick < 80) ? bsp_pkg::REQ_ADD_EDGE : bsp_pkg::REQ_FIND;
      end else if (pick < 8) begin
        r.req_type = bsp_pkg::REQ_ADD_NODE;
      end else if (pick < 35) begin
        r.req_type = bsp_pkg::REQ_ADD_EDGE;
      end else if (pick < 95) begin
        r.req_type = bsp_pkg::REQ_FIND;
      end else begin
        r.req_type = REQ_UNUSED;
      end
      send_req(r, 1'b0, none);
    end
    req_if.valid <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (400) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
